[hdl/fuls_pkg.sv]
// Shared types, constants and helpers for the firmware update link sequencer.
package fuls_pkg;

    localparam int EventDepth = 8;
    localparam int EvAw       = $clog2(EventDepth);
    localparam int EvCw       = $clog2(EventDepth + 1);
    localparam int LineCap    = 128;
    localparam int LcW        = $clog2(LineCap);
    localparam int ChunkMin   = 20;
    localparam int ChunkMax   = 512;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_VER    = 3'd1,
        PH_START  = 3'd2,
        PH_ERASE  = 3'd3,
        PH_SEND   = 3'd4,
        PH_FINISH = 3'd5,
        PH_DONE   = 3'd6,
        PH_FAIL   = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        ER_NONE    = 3'd0,
        ER_WRITE   = 3'd1,
        ER_TIMEOUT = 3'd2,
        ER_SILENT  = 3'd3,
        ER_REFUSED = 3'd4,
        ER_HASH    = 3'd5,
        ER_PROTO   = 3'd6
    } t_err;

    typedef enum logic [2:0] {
        EV_ACK     = 3'd0,
        EV_ERASING = 3'd1,
        EV_OK      = 3'd2,
        EV_ERR     = 3'd3,
        EV_ERRHASH = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        K_BEGIN  = 3'd0,
        K_BYTE   = 3'd1,
        K_WR_OK  = 3'd2,
        K_WR_BAD = 3'd3,
        K_TICK   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        WR_NONE    = 2'd0,
        WR_VERSION = 2'd1,
        WR_START   = 2'd2,
        WR_CHUNK   = 2'd3
    } t_wreq;

    typedef enum logic [2:0] {
        CFG_MTU    = 3'd0,
        CFG_T_VER  = 3'd1,
        CFG_T_STA  = 3'd2,
        CFG_T_ERA  = 3'd3,
        CFG_T_ACK  = 3'd4,
        CFG_T_FIN  = 3'd5
    } t_cfg;

    typedef enum logic [1:0] {
        SQ_IDLE  = 2'd0,
        SQ_DRAIN = 2'd1,
        SQ_CHECK = 2'd2,
        SQ_OUT   = 2'd3
    } t_seq;

    // Line matcher states.
    localparam logic [4:0] M_START = 5'd0;
    localparam logic [4:0] M_ACK   = 5'd3;
    localparam logic [4:0] M_ER    = 5'd5;
    localparam logic [4:0] M_ERAS  = 5'd10;
    localparam logic [4:0] M_ERR   = 5'd11;
    localparam logic [4:0] M_O     = 5'd12;
    localparam logic [4:0] M_OK    = 5'd13;
    localparam logic [4:0] M_OKSP  = 5'd14;
    localparam logic [4:0] M_OTHER = 5'd15;

    typedef struct packed {
        logic       push;
        t_event     ev;
    } t_push;

    function automatic logic [7:0] hash_char(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0:  c = "H";
            4'd1:  c = "a";
            4'd2:  c = "s";
            4'd3:  c = "h";
            4'd4:  c = " ";
            4'd5:  c = "M";
            4'd6:  c = "i";
            4'd7:  c = "s";
            4'd8:  c = "m";
            4'd9:  c = "a";
            4'd10: c = "t";
            4'd11: c = "c";
            4'd12: c = "h";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] next_match(input logic [4:0] s, input logic [7:0] c);
        logic [4:0] n;
        n = M_OTHER;
        case (s)
            5'd0: begin
                if (c == "A") n = 5'd1;
                else if (c == "E") n = 5'd4;
                else if (c == "O") n = M_O;
            end
            5'd1: if (c == "C") n = 5'd2;
            5'd2: if (c == "K") n = M_ACK;
            5'd4: if (c == "R") n = M_ER;
            5'd5: begin
                if (c == "R") n = M_ERR;
                else if (c == "A") n = 5'd6;
            end
            5'd6: if (c == "S") n = 5'd7;
            5'd7: if (c == "I") n = 5'd8;
            5'd8: if (c == "N") n = 5'd9;
            5'd9: if (c == "G") n = M_ERAS;
            5'd11: n = M_ERR;
            5'd12: if (c == "K") n = M_OK;
            5'd13: if (c == " ") n = M_OKSP;
            5'd14: n = M_OKSP;
            default: n = M_OTHER;
        endcase
        return n;
    endfunction

endpackage

[hdl/fuls_line_parser.sv]
// Assembles loader bytes into lines and recognises the event lines.
module fuls_line_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic            i_byte_en,
    input  logic [7:0]      i_byte,
    output fuls_pkg::t_push o_push
);

    logic [fuls_pkg::LcW-1:0] r_cnt, n_cnt;
    logic [4:0]               r_ms, n_ms;
    logic [3:0]               r_mm, n_mm;
    logic                     r_long, n_long;
    logic [3:0]               s;

    always_comb begin
        n_cnt  = r_cnt;
        n_ms   = r_ms;
        n_mm   = r_mm;
        n_long = r_long;
        o_push = '0;
        o_push.ev = fuls_pkg::EV_ACK;
        s = r_ms[3:0];
        if (i_clear) begin
            n_cnt = '0; n_ms = fuls_pkg::M_START; n_mm = '0; n_long = 1'b0;
        end else if (i_byte_en) begin
            if (i_byte == 8'h0A) begin
                if (!r_long) begin
                    if ({1'b0, s} == fuls_pkg::M_ACK) begin
                        o_push.push = 1'b1; o_push.ev = fuls_pkg::EV_ACK;
                    end else if ({1'b0, s} == fuls_pkg::M_ERAS) begin
                        o_push.push = 1'b1; o_push.ev = fuls_pkg::EV_ERASING;
                    end else if ({1'b0, s} == fuls_pkg::M_OK || {1'b0, s} == fuls_pkg::M_OKSP) begin
                        o_push.push = 1'b1; o_push.ev = fuls_pkg::EV_OK;
                    end else if ({1'b0, s} == fuls_pkg::M_ERR) begin
                        o_push.push = 1'b1;
                        o_push.ev = (r_mm >= 4'd13) ? fuls_pkg::EV_ERRHASH : fuls_pkg::EV_ERR;
                    end
                end
                n_cnt = '0; n_ms = fuls_pkg::M_START; n_mm = '0; n_long = 1'b0;
            end else if (i_byte != 8'h0D) begin
                if ({1'b0, r_cnt} + 1 >= (fuls_pkg::LcW+1)'(fuls_pkg::LineCap)) begin
                    n_long = 1'b1;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    if (!r_ms[4]) begin
                        if (i_byte == 8'd0) begin
                            n_ms = r_ms | 5'd16;
                        end else begin
                            if (r_ms == fuls_pkg::M_ERR && r_mm < 4'd13) begin
                                if (i_byte == fuls_pkg::hash_char(r_mm)) n_mm = r_mm + 1'b1;
                                else n_mm = (i_byte == "H") ? 4'd1 : 4'd0;
                            end
                            n_ms = fuls_pkg::next_match(r_ms, i_byte);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_ms <= fuls_pkg::M_START; r_mm <= '0; r_long <= 1'b0;
        end else begin
            r_cnt <= n_cnt; r_ms <= n_ms; r_mm <= n_mm; r_long <= n_long;
        end
    end

endmodule

[hdl/fuls_event_queue.sv]
// Circular event queue with loss flag.
module fuls_event_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  fuls_pkg::t_push             i_push,
    input  logic                        i_pop,
    output fuls_pkg::t_event            o_head_ev,
    output logic                        o_empty,
    output logic                        o_lost
);

    logic [2:0]                r_mem [fuls_pkg::EventDepth];
    logic [fuls_pkg::EvAw-1:0] r_head;
    logic [fuls_pkg::EvCw-1:0] r_count;
    logic                      r_lost;
    logic [fuls_pkg::EvAw-1:0] wr_addr;
    logic                      full;

    assign full    = r_count == fuls_pkg::EvCw'(fuls_pkg::EventDepth);
    assign wr_addr = r_head + r_count[fuls_pkg::EvAw-1:0];
    assign o_empty = r_count == '0;
    assign o_lost  = r_lost;
    assign o_head_ev = fuls_pkg::t_event'(r_mem[r_head]);

    always_ff @(posedge i_clk) begin
        if (i_push.push && !full && !i_clear) begin
            r_mem[wr_addr] <= i_push.ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0; r_count <= '0; r_lost <= 1'b0;
        end else if (i_clear) begin
            r_head <= '0; r_count <= '0; r_lost <= 1'b0;
        end else if (i_pop) begin
            r_head  <= r_head + 1'b1;
            r_count <= r_count - 1'b1;
        end else if (i_push.push) begin
            if (full) r_lost <= 1'b1;
            else r_count <= r_count + 1'b1;
        end
    end

endmodule

[hdl/firmware_update_link_sequencer.sv]
// Top level of the firmware update link sequencer.
//  channel | direction | handshake
//  in      | input     | i_valid / o_stall
//  out     | output    | o_valid / i_stall
//  cfg     | input     | i_cfg_we, i_cfg_index, i_cfg_data
// A begin, byte, write report, idle tick or unknown item passes from acceptance through the
// output state to the result. A tick during a transfer first drains queued events, then
// checks the deadline and passes through the output state to the result.
// Reset is synchronous and active low; it restores the register reset values.
// Input is stalled while a transfer is held or an item is at work.
module firmware_update_link_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_byte_value,
    input  logic [23:0] i_image_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_write_request,
    output logic [23:0] o_chunk_offset,
    output logic [9:0]  o_chunk_length,
    output logic [23:0] o_image_total,
    output logic [2:0]  o_phase,
    output logic [2:0]  o_error_code,
    output logic [23:0] o_acked_bytes,
    output logic        o_begin_refused,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    fuls_pkg::t_seq   r_sq, n_sq;
    fuls_pkg::t_phase r_ph, n_ph;
    fuls_pkg::t_err   r_err, n_err;
    logic        r_wp, n_wp;
    logic [23:0] r_tot, n_tot, r_ack, n_ack;
    logic [9:0]  r_fl, n_fl;
    logic [15:0] r_dl, n_dl;
    logic [15:0] r_cfg [6];
    logic [1:0]  r_req, n_req;
    logic [23:0] r_off, n_off, r_itot, n_itot;
    logic [9:0]  r_len, n_len;
    logic        r_ref, n_ref;
    logic        r_ov, n_ov;

    logic            take, busy, q_empty, q_lost, pop, qclr, done;
    fuls_pkg::t_push push;
    fuls_pkg::t_event hev;
    logic [9:0]  chunk;
    logic [23:0] left;
    logic        clr_beg;

    assign take = i_valid && !o_stall;
    assign o_stall = (r_sq != fuls_pkg::SQ_IDLE) || r_ov;
    assign busy = r_ph >= fuls_pkg::PH_VER && r_ph <= fuls_pkg::PH_FINISH;

    fuls_line_parser u_parse (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(clr_beg),
        .i_byte_en(take && i_kind == fuls_pkg::K_BYTE), .i_byte(i_byte_value),
        .o_push(push)
    );

    assign qclr = clr_beg;
    fuls_event_queue u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(qclr), .i_push(push),
        .i_pop(pop), .o_head_ev(hev), .o_empty(q_empty), .o_lost(q_lost)
    );

    assign clr_beg = take && i_kind == fuls_pkg::K_BEGIN && !busy && i_image_length != '0;

    always_comb begin
        if (r_cfg[fuls_pkg::CFG_MTU] < 16'd23) chunk = 10'(fuls_pkg::ChunkMin);
        else if (r_cfg[fuls_pkg::CFG_MTU] - 16'd3 > 16'(fuls_pkg::ChunkMax))
            chunk = 10'(fuls_pkg::ChunkMax);
        else chunk = 10'(r_cfg[fuls_pkg::CFG_MTU] - 16'd3);
    end

    always_comb begin
        n_sq = r_sq;
        case (r_sq)
            fuls_pkg::SQ_IDLE:  if (take) n_sq = (i_kind == fuls_pkg::K_TICK && busy)
                                    ? fuls_pkg::SQ_DRAIN : fuls_pkg::SQ_OUT;
            fuls_pkg::SQ_DRAIN: if (done) n_sq = fuls_pkg::SQ_CHECK;
            fuls_pkg::SQ_CHECK: n_sq = fuls_pkg::SQ_OUT;
            fuls_pkg::SQ_OUT:   n_sq = fuls_pkg::SQ_IDLE;
            default:            n_sq = fuls_pkg::SQ_IDLE;
        endcase
    end

    always_comb begin
        n_ph = r_ph; n_err = r_err; n_wp = r_wp; n_tot = r_tot; n_ack = r_ack;
        n_fl = r_fl; n_dl = r_dl; n_req = r_req; n_off = r_off; n_len = r_len;
        n_itot = r_itot; n_ref = r_ref; pop = 1'b0; done = 1'b1;
        left = r_tot - r_ack;
        case (r_sq)
            fuls_pkg::SQ_IDLE: if (take) begin
                n_req = fuls_pkg::WR_NONE; n_off = '0; n_len = '0; n_itot = '0; n_ref = 1'b0;
                case (i_kind)
                    fuls_pkg::K_BEGIN: begin
                        if (busy || i_image_length == '0) n_ref = 1'b1;
                        else begin
                            n_tot = i_image_length; n_ack = '0; n_fl = '0;
                            n_err = fuls_pkg::ER_NONE; n_ph = fuls_pkg::PH_VER;
                            n_dl = r_cfg[fuls_pkg::CFG_T_VER];
                            n_req = fuls_pkg::WR_VERSION; n_wp = 1'b1;
                        end
                    end
                    fuls_pkg::K_WR_OK: n_wp = 1'b0;
                    fuls_pkg::K_WR_BAD: begin
                        if (busy && r_wp) begin
                            n_ph = fuls_pkg::PH_FAIL; n_err = fuls_pkg::ER_WRITE;
                        end
                        n_wp = 1'b0;
                    end
                    fuls_pkg::K_TICK: if (busy) begin
                        if (q_lost) begin
                            n_ph = fuls_pkg::PH_FAIL; n_err = fuls_pkg::ER_PROTO;
                        end else if (r_dl != '0) n_dl = r_dl - 1'b1;
                    end
                    default: ;
                endcase
            end
            fuls_pkg::SQ_DRAIN: begin
                done = q_empty || !busy;
                if (!done) begin
                    pop = 1'b1;
                    if (hev == fuls_pkg::EV_ERR || hev == fuls_pkg::EV_ERRHASH) begin
                        n_ph = fuls_pkg::PH_FAIL;
                        n_err = (hev == fuls_pkg::EV_ERRHASH) ? fuls_pkg::ER_HASH
                                                              : fuls_pkg::ER_REFUSED;
                    end else begin
                        case (r_ph)
                            fuls_pkg::PH_VER: begin
                                if (hev != fuls_pkg::EV_OK) begin
                                    n_ph = fuls_pkg::PH_FAIL; n_err = fuls_pkg::ER_PROTO;
                                end else if (r_wp) begin
                                    pop = 1'b0; done = 1'b1;
                                end else begin
                                    n_ph = fuls_pkg::PH_START;
                                    n_dl = r_cfg[fuls_pkg::CFG_T_STA];
                                    n_req = fuls_pkg::WR_START; n_itot = r_tot; n_wp = 1'b1;
                                end
                            end
                            fuls_pkg::PH_START, fuls_pkg::PH_ERASE: begin
                                if (r_ph == fuls_pkg::PH_START && hev == fuls_pkg::EV_ERASING) begin
                                    n_ph = fuls_pkg::PH_ERASE;
                                    n_dl = r_cfg[fuls_pkg::CFG_T_ERA];
                                end else if (hev != fuls_pkg::EV_OK) begin
                                    n_ph = fuls_pkg::PH_FAIL; n_err = fuls_pkg::ER_PROTO;
                                end else if (r_wp) begin
                                    pop = 1'b0; done = 1'b1;
                                end else begin
                                    n_fl = (left < 24'(chunk)) ? left[9:0] : chunk;
                                    n_ph = (left <= 24'(chunk)) ? fuls_pkg::PH_FINISH
                                                               : fuls_pkg::PH_SEND;
                                    n_dl = (left <= 24'(chunk)) ? r_cfg[fuls_pkg::CFG_T_FIN]
                                                               : r_cfg[fuls_pkg::CFG_T_ACK];
                                    n_req = fuls_pkg::WR_CHUNK; n_off = r_ack; n_len = n_fl;
                                    n_wp = 1'b1;
                                end
                            end
                            fuls_pkg::PH_SEND: begin
                                if (hev != fuls_pkg::EV_ACK || r_fl == '0) begin
                                    n_ph = fuls_pkg::PH_FAIL; n_err = fuls_pkg::ER_PROTO;
                                end else if (r_wp) begin
                                    pop = 1'b0; done = 1'b1;
                                end else begin
                                    n_ack = r_ack + 24'(r_fl);
                                    left = r_tot - n_ack;
                                    n_fl = (left < 24'(chunk)) ? left[9:0] : chunk;
                                    n_ph = (left <= 24'(chunk)) ? fuls_pkg::PH_FINISH
                                                               : fuls_pkg::PH_SEND;
                                    n_dl = (left <= 24'(chunk)) ? r_cfg[fuls_pkg::CFG_T_FIN]
                                                               : r_cfg[fuls_pkg::CFG_T_ACK];
                                    n_req = fuls_pkg::WR_CHUNK; n_off = n_ack; n_len = n_fl;
                                    n_wp = 1'b1;
                                end
                            end
                            fuls_pkg::PH_FINISH: begin
                                if (hev != fuls_pkg::EV_OK) begin
                                    n_ph = fuls_pkg::PH_FAIL; n_err = fuls_pkg::ER_PROTO;
                                end else begin
                                    n_ack = r_ack + 24'(r_fl); n_fl = '0;
                                    n_ph = fuls_pkg::PH_DONE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            fuls_pkg::SQ_CHECK: begin
                if (busy && r_dl == '0) begin
                    n_ph = fuls_pkg::PH_FAIL;
                    n_err = (r_ph == fuls_pkg::PH_VER) ? fuls_pkg::ER_SILENT
                                                       : fuls_pkg::ER_TIMEOUT;
                end
            end
            default: ;
        endcase
    end

    assign n_ov = (r_sq == fuls_pkg::SQ_OUT) ? 1'b1 : (r_ov && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq <= fuls_pkg::SQ_IDLE; r_ph <= fuls_pkg::PH_IDLE; r_err <= fuls_pkg::ER_NONE;
            r_wp <= 1'b0; r_tot <= '0; r_ack <= '0; r_fl <= '0; r_dl <= '0; r_ov <= 1'b0;
            r_req <= '0; r_off <= '0; r_len <= '0; r_itot <= '0; r_ref <= 1'b0;
            r_cfg[0] <= 16'd23;    r_cfg[1] <= 16'd10000; r_cfg[2] <= 16'd10000;
            r_cfg[3] <= 16'd60000; r_cfg[4] <= 16'd10000; r_cfg[5] <= 16'd30000;
        end else begin
            r_sq <= n_sq; r_ph <= n_ph; r_err <= n_err; r_wp <= n_wp; r_tot <= n_tot;
            r_ack <= n_ack; r_fl <= n_fl; r_dl <= n_dl; r_ov <= n_ov;
            r_req <= n_req; r_off <= n_off; r_len <= n_len; r_itot <= n_itot; r_ref <= n_ref;
            if (i_cfg_we && i_cfg_index <= fuls_pkg::CFG_T_FIN) r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    assign o_valid         = r_ov;
    assign o_write_request = r_req;
    assign o_chunk_offset  = r_off;
    assign o_chunk_length  = r_len;
    assign o_image_total   = r_itot;
    assign o_phase         = r_ph;
    assign o_error_code    = r_err;
    assign o_acked_bytes   = r_ack;
    assign o_begin_refused = r_ref;

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq != fuls_pkg::SQ_IDLE |-> !take) else $error("input taken mid-item");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq == fuls_pkg::SQ_OUT |=> o_valid) else $error("result not presented");
    a_fail_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ph == fuls_pkg::PH_FAIL |-> r_err != fuls_pkg::ER_NONE)
        else $error("failure without code");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_phase) && $stable(o_acked_bytes))
        else $error("stalled result changed");
`endif

endmodule
